/* rtl/rmslvl_pkg.sv */
// constants, field widths and register codes of the per-channel rms level tracker
// no dependencies; imported by per_channel_rms_level_tracker_top
package rmslvl_pkg;

    // sizing
    localparam int CHANNELS  = 64;
    localparam int FRAME_MAX = 4096;

    // field widths
    localparam int CH_W   = 6;
    localparam int SMP_W  = 16;
    localparam int TIME_W = 32;
    localparam int LVL_W  = 16;
    localparam int SUM_W  = 43;
    localparam int CNT_W  = 13;
    localparam int FACT_W = 15;
    localparam int HOLD_W = 16;
    localparam int Q_FRAC = 15;

    // iterative divide and square root
    localparam int REM_W  = CNT_W + 1;
    localparam int RAD_W  = SUM_W + 1;
    localparam int ROOT_W = RAD_W / 2;
    localparam int SREM_W = ROOT_W + 4;
    localparam int STEP_W = 6;

    // stream and configuration port widths
    localparam int S_TDATA_W  = 56;
    localparam int S_PAD_W    = S_TDATA_W - CH_W - SMP_W - TIME_W;
    localparam int M_TDATA_W  = 24;
    localparam int M_PAD_W    = M_TDATA_W - CH_W - LVL_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS      = 2'd2;

    // register reset values
    localparam logic              RST_DECAY_ENABLE = 1'b1;
    localparam logic [FACT_W-1:0] RST_DECAY_FACTOR = 15'd27853;
    localparam logic [HOLD_W-1:0] RST_HOLD_MS      = 16'd40;

    // item kinds
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    // q1.15 constants
    localparam logic [FACT_W-1:0] BLEND_OLD   = 15'd18022;
    localparam logic [FACT_W-1:0] BLEND_NEW   = 15'd14746;
    localparam logic [FACT_W-1:0] DECAY_LO    = 15'd3277;
    localparam logic [FACT_W-1:0] DECAY_HI    = 15'd32440;
    localparam logic [LVL_W-1:0]  FLUSH_BELOW = 16'd33;
    localparam logic [LVL_W-1:0]  LEVEL_FULL  = 16'd32768;

endpackage

/* rtl/per_channel_rms_level_tracker_top.sv */
// per-channel rms level tracker: frame rms, attack/release blend, hold and decay
// depends on rmslvl_pkg; one shared multiplier, separate subtract/compare logic for divide and root
//
// Usage
//   input stream s_*: tuser selects the item kind (0 sample, 1 tick), tlast marks the
//   last sample of a frame, tdata carries channel, sample and now_ms.
//   result stream m_*: tdata carries channel and level (q1.15), tuser is 1 for tick
//   readout, tlast marks the final result of one input item.
//   cfg_*: one write per cycle when cfg_we is high, index 0 decay_enable,
//   1 decay_factor, 2 hold_ms; factor sampled at item accept, enable and hold read live.
// Timing
//   one item at a time; s_tready is high only while the sequencer is idle.
//   plain sample: accept, square, accumulate.
//   frame end: the one-bit-per-cycle divide (43 steps), the two-bit-per-cycle
//   square root (22 steps), then the blend multiplies.
//   tick: read, multiply and output steps for each channel after the accept,
//   set by the single level/time memory read port and the shared multiplier.
//   a stalled receiver holds the sequencer when it has a result to hand over; the
//   last result may wait in the output register while the next item is accepted.
// Reset
//   aresetn (synchronous, low) restores register defaults, clears the frame sum,
//   and marks every channel level and talk time as zero through per-channel valid bits.
module per_channel_rms_level_tracker_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input items
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [rmslvl_pkg::S_TDATA_W-1:0]      s_tdata,   // channel, sample, now_ms, pad
    input  logic                                  s_tuser,   // func
    input  logic                                  s_tlast,   // frame_end
    // result items
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [rmslvl_pkg::M_TDATA_W-1:0]      m_tdata,   // out_channel, level, pad
    output logic                                  m_tuser,   // from_tick
    output logic                                  m_tlast,   // last_of_run
    // configuration writes
    input  logic                                  cfg_we,
    input  logic [rmslvl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rmslvl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import rmslvl_pkg::*;

    // sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQ   = 4'd1;
    localparam logic [3:0] ST_ACC  = 4'd2;
    localparam logic [3:0] ST_DIV  = 4'd3;
    localparam logic [3:0] ST_SQRT = 4'd4;
    localparam logic [3:0] ST_BL1  = 4'd5;
    localparam logic [3:0] ST_BL2  = 4'd6;
    localparam logic [3:0] ST_FOUT = 4'd7;
    localparam logic [3:0] ST_TRD  = 4'd8;
    localparam logic [3:0] ST_TMUL = 4'd9;
    localparam logic [3:0] ST_TOUT = 4'd10;

    logic [3:0]         state_reg, state_next;

    // configuration registers
    logic               en_reg;
    logic [FACT_W-1:0]  factor_reg;
    logic [HOLD_W-1:0]  hold_reg;

    // captured item fields
    logic               fend_reg;
    logic [CH_W-1:0]    ch_reg;
    logic [SMP_W-1:0]   smp_reg;
    logic [TIME_W-1:0]  now_reg;

    // frame accumulator
    logic [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]   cnt_reg;

    // shared datapath registers
    logic [2*LVL_W-1:0] prod_reg, acc_reg;
    logic [SUM_W-1:0]   quo_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   dvs_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [RAD_W-1:0]   rad_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [SREM_W-1:0]  srem_reg;
    logic [LVL_W-1:0]   fresh_reg;
    logic [CH_W-1:0]    idx_reg;
    logic [FACT_W-1:0]  clamp_reg;
    logic               dec_reg;

    // level and talk time memories with reset valid bits
    logic [LVL_W-1:0]   level_mem [CHANNELS];
    logic [TIME_W-1:0]  time_mem  [CHANNELS];
    logic [CHANNELS-1:0] vld_reg;
    logic [LVL_W-1:0]   lvl_rd_reg;
    logic [TIME_W-1:0]  time_rd_reg;
    logic               vld_rd_reg;

    // output register
    logic               m_tvalid_reg;
    logic [CH_W-1:0]    out_ch_reg;
    logic [LVL_W-1:0]   out_lvl_reg;
    logic               out_tick_reg;
    logic               out_last_reg;

    // combinational helpers
    logic               in_acc;
    logic               out_free;
    logic               out_load;
    logic [CH_W-1:0]    mem_addr;
    logic               lvl_we, time_we;
    logic [LVL_W-1:0]   lvl_wd;
    logic [LVL_W-1:0]   old_lvl;
    logic [TIME_W-1:0]  old_time;
    logic [SMP_W-1:0]   mag;
    logic [LVL_W-1:0]   mul_a, mul_b;
    logic [2*LVL_W-1:0] mul_p;
    logic               acc_take;
    logic [SUM_W-1:0]   sum_new;
    logic [CNT_W-1:0]   cnt_new;
    logic [REM_W-1:0]   div_trial, div_diff;
    logic               div_ge;
    logic [SUM_W-1:0]   quo_next;
    logic [SREM_W-1:0]  sq_rem_sh, sq_trial;
    logic               sq_ge;
    logic [ROOT_W-1:0]  root_next;
    logic [LVL_W-1:0]   fresh_calc;
    logic               ch_ok;
    logic [2*LVL_W:0]   blend_sum;
    logic [LVL_W-1:0]   frame_lvl;
    logic [LVL_W-1:0]   dec_raw, dec_lvl, tick_lvl;
    logic [FACT_W-1:0]  clamp_calc;
    logic               tick_last;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg     <= RST_DECAY_ENABLE;
            factor_reg <= RST_DECAY_FACTOR;
            hold_reg   <= RST_HOLD_MS;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_DECAY_ENABLE: en_reg     <= cfg_wdata[0];
                CFG_DECAY_FACTOR: factor_reg <= cfg_wdata[FACT_W-1:0];
                CFG_HOLD_MS:      hold_reg   <= cfg_wdata[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // memory read data with unwritten entries seen as zero
    assign old_lvl  = vld_rd_reg ? lvl_rd_reg : '0;
    assign old_time = vld_rd_reg ? time_rd_reg : '0;

    // sample magnitude
    assign mag = smp_reg[SMP_W-1] ? (SMP_W'(0) - smp_reg) : smp_reg;

    // shared multiplier operand select
    always_comb begin
        case (state_reg)
            ST_SQ: begin
                mul_a = mag;
                mul_b = mag;
            end
            ST_BL1: begin
                mul_a = old_lvl;
                mul_b = LVL_W'(BLEND_OLD);
            end
            ST_BL2: begin
                mul_a = fresh_reg;
                mul_b = LVL_W'(BLEND_NEW);
            end
            ST_TMUL: begin
                mul_a = old_lvl;
                mul_b = LVL_W'(clamp_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // accumulate unless the frame is full
    assign acc_take = (cnt_reg < CNT_W'(FRAME_MAX));
    assign sum_new  = acc_take ? (sum_reg + SUM_W'(prod_reg)) : sum_reg;
    assign cnt_new  = acc_take ? (cnt_reg + CNT_W'(1)) : cnt_reg;

    // restoring divide step, one quotient bit per cycle
    assign div_trial = {rem_reg[CNT_W-1:0], quo_reg[SUM_W-1]};
    assign div_diff  = div_trial - {1'b0, dvs_reg};
    assign div_ge    = (div_trial >= {1'b0, dvs_reg});
    assign quo_next  = {quo_reg[SUM_W-2:0], div_ge};

    // square root step, two radicand bits per cycle
    assign sq_rem_sh = {srem_reg[SREM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign sq_trial  = {{(SREM_W-ROOT_W-2){1'b0}}, root_reg, 2'b01};
    assign sq_ge     = (sq_rem_sh >= sq_trial);
    assign root_next = {root_reg[ROOT_W-2:0], sq_ge};
    assign fresh_calc = (root_next > ROOT_W'(LEVEL_FULL)) ? LEVEL_FULL
                                                          : root_next[LVL_W-1:0];
    assign ch_ok = ({1'b0, ch_reg} < (CH_W+1)'(CHANNELS));

    // attack takes the louder level, release blends
    assign blend_sum = {1'b0, acc_reg} + {1'b0, prod_reg};
    assign frame_lvl = (fresh_reg > old_lvl) ? fresh_reg : blend_sum[Q_FRAC +: LVL_W];

    // decay with flush to zero
    assign dec_raw  = prod_reg[Q_FRAC +: LVL_W];
    assign dec_lvl  = (dec_raw < FLUSH_BELOW) ? '0 : dec_raw;
    assign tick_lvl = dec_reg ? dec_lvl : old_lvl;
    assign tick_last = (idx_reg == CH_W'(CHANNELS - 1));

    // release factor clamp
    assign clamp_calc = (factor_reg < DECAY_LO) ? DECAY_LO :
                        (factor_reg > DECAY_HI) ? DECAY_HI : factor_reg;

    // memory port control
    assign mem_addr = (state_reg == ST_TRD || state_reg == ST_TMUL ||
                       state_reg == ST_TOUT) ? idx_reg : ch_reg;
    assign out_load = out_free && (state_reg == ST_FOUT || state_reg == ST_TOUT);
    assign time_we  = out_load && (state_reg == ST_FOUT);
    assign lvl_we   = time_we || (out_load && (state_reg == ST_TOUT) && dec_reg);
    assign lvl_wd   = (state_reg == ST_FOUT) ? frame_lvl : dec_lvl;

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    state_next = (s_tuser == FUNC_TICK) ? ST_TRD : ST_SQ;
                end
            end
            ST_SQ:   state_next = ST_ACC;
            ST_ACC:  state_next = fend_reg ? ST_DIV : ST_IDLE;
            ST_DIV: begin
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (step_reg == STEP_W'(ROOT_W - 1)) begin
                    state_next = ch_ok ? ST_BL1 : ST_IDLE;
                end
            end
            ST_BL1:  state_next = ST_BL2;
            ST_BL2:  state_next = ST_FOUT;
            ST_FOUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_TRD:  state_next = ST_TMUL;
            ST_TMUL: state_next = ST_TOUT;
            ST_TOUT: begin
                if (out_free) begin
                    state_next = tick_last ? ST_IDLE : ST_TRD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state and frame accumulator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sum_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_ACC) begin
                if (fend_reg) begin
                    sum_reg <= '0;
                    cnt_reg <= '0;
                end else begin
                    sum_reg <= sum_new;
                    cnt_reg <= cnt_new;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    ch_reg    <= s_tdata[CH_W-1:0];
                    smp_reg   <= s_tdata[CH_W +: SMP_W];
                    now_reg   <= s_tdata[CH_W+SMP_W +: TIME_W];
                    fend_reg  <= s_tlast;
                    clamp_reg <= clamp_calc;
                    idx_reg   <= '0;
                end
            end
            ST_SQ: prod_reg <= mul_p;
            ST_ACC: begin
                quo_reg  <= sum_new;
                dvs_reg  <= cnt_new;
                rem_reg  <= '0;
                step_reg <= '0;
            end
            ST_DIV: begin
                quo_reg  <= quo_next;
                rem_reg  <= div_ge ? div_diff : div_trial;
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    rad_reg  <= (dvs_reg == '0) ? '0 : {1'b0, quo_next};
                    root_reg <= '0;
                    srem_reg <= '0;
                    step_reg <= '0;
                end else begin
                    step_reg <= step_reg + STEP_W'(1);
                end
            end
            ST_SQRT: begin
                srem_reg  <= sq_ge ? (sq_rem_sh - sq_trial) : sq_rem_sh;
                root_reg  <= root_next;
                rad_reg   <= {rad_reg[RAD_W-3:0], 2'b00};
                step_reg  <= step_reg + STEP_W'(1);
                fresh_reg <= fresh_calc;
            end
            ST_BL1: prod_reg <= mul_p;
            ST_BL2: begin
                acc_reg  <= prod_reg;
                prod_reg <= mul_p;
            end
            ST_TMUL: begin
                prod_reg <= mul_p;
                dec_reg  <= en_reg && (old_lvl != '0) &&
                            ((now_reg - old_time) >= TIME_W'(hold_reg));
            end
            ST_TOUT: begin
                if (out_free && !tick_last) begin
                    idx_reg <= idx_reg + CH_W'(1);
                end
            end
            default: ;
        endcase
    end

    // level and talk time memories, registered read
    always_ff @(posedge aclk) begin
        if (lvl_we) begin
            level_mem[mem_addr] <= lvl_wd;
        end
        if (time_we) begin
            time_mem[mem_addr] <= now_reg;
        end
        lvl_rd_reg  <= level_mem[mem_addr];
        time_rd_reg <= time_mem[mem_addr];
    end

    // per-channel valid bits stand in for the memory reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            vld_rd_reg <= 1'b0;
        end else begin
            if (time_we) begin
                vld_reg[mem_addr] <= 1'b1;
            end
            vld_rd_reg <= vld_reg[mem_addr];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (state_reg == ST_FOUT) begin
                out_ch_reg   <= ch_reg;
                out_lvl_reg  <= frame_lvl;
                out_tick_reg <= 1'b0;
                out_last_reg <= 1'b1;
            end else begin
                out_ch_reg   <= idx_reg;
                out_lvl_reg  <= tick_lvl;
                out_tick_reg <= 1'b1;
                out_last_reg <= tick_last;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_lvl_reg, out_ch_reg};
    assign m_tuser  = out_tick_reg;
    assign m_tlast  = out_last_reg;

    // a frame-end result is always the single result of its item
    a_frame_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !out_tick_reg |-> out_last_reg)
        else $error("frame-end result without last mark");

    // tracked levels stay within full scale
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (out_lvl_reg <= LEVEL_FULL))
        else $error("level above full scale");

    // the frame count never passes the frame limit
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(FRAME_MAX))
        else $error("sample count above frame limit");

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready held after accepting an item");

    // the tick walk only hands over results while its index is in range
    a_tick_index: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_TOUT |-> ({1'b0, idx_reg} < (CH_W+1)'(CHANNELS)))
        else $error("tick walk index out of range");

endmodule

/* bench/tb.sv */
// self-checking bench for per_channel_rms_level_tracker_top: directed items from a table,
// then random framed traffic under several register settings, results checked in order
// depends on rmslvl_pkg and the tracker rtl only
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rmslvl_pkg::*;

    // one input item and one level report
    typedef struct packed {
        logic              func;
        logic [CH_W-1:0]   ch;
        logic [SMP_W-1:0]  smp;
        logic              fend;
        logic [TIME_W-1:0] now;
    } pcm_item_t;

    typedef struct packed {
        logic [CH_W-1:0]  ch;
        logic [LVL_W-1:0] lvl;
        logic             tick;
        logic             last;
    } level_rpt_t;

    // directed row: item plus a level typed in by hand, -1 when the tracker model decides
    typedef struct {
        pcm_item_t item;
        int        want;
    } bench_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_DECAY_ENABLE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // shadow of the tracker state and registers
    logic [SUM_W-1:0]  frame_sq_sum;
    logic [CNT_W-1:0]  frame_len;
    logic [LVL_W-1:0]  level_mem [CHANNELS];
    logic [TIME_W-1:0] talk_mem  [CHANNELS];
    logic              decay_on;
    logic [FACT_W-1:0] decay_mul;
    logic [HOLD_W-1:0] hold_len;

    level_rpt_t  level_due [$];
    bench_row_t  rows [$];
    logic [31:0] clock_ms;
    bit          calm;
    bit          hold_off_req;
    int unsigned mismatch_count;
    int unsigned results_seen;
    int unsigned items_sent;
    int unsigned ticks_sent;
    int unsigned frames_sent;

    per_channel_rms_level_tracker_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // channel, sample, now_ms, pad
        .s_tuser   (s_tuser),    // func
        .s_tlast   (s_tlast),    // frame_end
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // out_channel, level, pad
        .m_tuser   (m_tuser),    // from_tick
        .m_tlast   (m_tlast),    // last_of_run
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // floor square root, one result bit per step from the top
    function automatic longint unsigned root_of(input longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 22; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) begin
                r = t;
            end
        end
        return r;
    endfunction

    // advance the shadow state by one accepted item and queue the levels it reports
    function automatic void track_level(input pcm_item_t it, input int want);
        longint unsigned mag;
        longint unsigned mean;
        int unsigned     fresh;
        int unsigned     prev;
        int unsigned     fac;
        logic [31:0]     quiet_ms;
        level_rpt_t      r;
        if (it.func == FUNC_SAMPLE) begin
            // samples past a full frame are dropped, their end mark still counts
            if (frame_len < FRAME_MAX) begin
                mag = it.smp[SMP_W-1] ? (65536 - it.smp) : it.smp;
                frame_sq_sum = SUM_W'(frame_sq_sum + mag * mag);
                frame_len = frame_len + 1'b1;
            end
            if (!it.fend) begin
                return;
            end
            mean = (frame_len != 0) ? (64'(frame_sq_sum) / frame_len) : 0;
            fresh = int'(root_of(mean));
            if (fresh > LEVEL_FULL) begin
                fresh = LEVEL_FULL;
            end
            frame_sq_sum = '0;
            frame_len = '0;
            if (int'(it.ch) >= CHANNELS) begin
                return;
            end
            // attack at once, release through the blend
            prev = level_mem[it.ch];
            if (fresh > prev) begin
                prev = fresh;
            end else begin
                prev = (prev * BLEND_OLD + fresh * BLEND_NEW) >> Q_FRAC;
            end
            level_mem[it.ch] = prev[LVL_W-1:0];
            talk_mem[it.ch] = it.now;
            r.ch = it.ch;
            r.lvl = (want >= 0) ? want[LVL_W-1:0] : level_mem[it.ch];
            r.tick = 1'b0;
            r.last = 1'b1;
            level_due.push_back(r);
        end else begin
            fac = decay_mul;
            if (fac < DECAY_LO) begin
                fac = DECAY_LO;
            end else if (fac > DECAY_HI) begin
                fac = DECAY_HI;
            end
            // decay channels silent for the hold time, flush tiny levels
            for (int i = 0; i < CHANNELS; i++) begin
                quiet_ms = it.now - talk_mem[i];
                if (decay_on && level_mem[i] != 0 && quiet_ms >= hold_len) begin
                    prev = (level_mem[i] * fac) >> Q_FRAC;
                    if (prev < FLUSH_BELOW) begin
                        prev = 0;
                    end
                    level_mem[i] = prev[LVL_W-1:0];
                end
            end
            // readout of every channel
            for (int i = 0; i < CHANNELS; i++) begin
                r.ch = i[CH_W-1:0];
                r.lvl = (want >= 0) ? want[LVL_W-1:0] : level_mem[i];
                r.tick = 1'b1;
                r.last = (i == CHANNELS - 1);
                level_due.push_back(r);
            end
        end
    endfunction

    function automatic void add_row(input logic func, input int ch, input int smp,
                                    input logic fend, input logic [31:0] now, input int want);
        bench_row_t row;
        row.item.func = func;
        row.item.ch = ch[CH_W-1:0];
        row.item.smp = smp[SMP_W-1:0];
        row.item.fend = fend;
        row.item.now = now;
        row.want = want;
        rows.push_back(row);
    endfunction

    // offer one item, at times with a random gap ahead of it, and wait until it is taken
    task automatic offer(input pcm_item_t it, input int want);
        int unsigned n;
        if (!calm && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.func;
        s_tlast <= it.fend;
        s_tdata <= {{S_PAD_W{1'b0}}, it.now, it.smp, it.ch};
        do @(posedge aclk); while (!s_tready);
        track_level(it, want);
        items_sent++;
        if (it.func == FUNC_TICK) begin
            ticks_sent++;
        end else if (it.fend) begin
            frames_sent++;
        end
    endtask

    // stop offering, wait for every queued level, then let the sequencer finish
    task automatic settle(input int unsigned tail);
        int unsigned waited;
        s_tvalid <= 1'b0;
        waited = 0;
        while (level_due.size() != 0 && waited < 200000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (tail) @(posedge aclk);
    endtask

    // write all three registers back to back
    task automatic load_regs(input logic [15:0] en_w, input logic [15:0] fac_w,
                             input logic [15:0] hold_w);
        cfg_we <= 1'b1;
        cfg_index <= CFG_DECAY_ENABLE;
        cfg_wdata <= en_w;
        @(posedge aclk);
        cfg_index <= CFG_DECAY_FACTOR;
        cfg_wdata <= fac_w;
        @(posedge aclk);
        cfg_index <= CFG_HOLD_MS;
        cfg_wdata <= hold_w;
        @(posedge aclk);
        cfg_we <= 1'b0;
        decay_on = en_w[0];
        decay_mul = fac_w[FACT_W-1:0];
        hold_len = hold_w;
    endtask

    // frames of random length and content, some ticks in between
    task automatic random_traffic(input int unsigned count);
        pcm_item_t   it;
        int unsigned len;
        int unsigned style;
        int unsigned k;
        logic [CH_W-1:0] ch;
        k = 0;
        while (k < count) begin
            clock_ms += $urandom_range(0, 25);
            if ($urandom_range(0, 39) == 0) begin
                clock_ms += $urandom;
            end
            if ($urandom_range(0, 99) < 8) begin
                // tick with junk in the unused fields
                it.func = FUNC_TICK;
                it.ch = CH_W'($urandom);
                it.smp = SMP_W'($urandom);
                it.fend = 1'($urandom);
                it.now = clock_ms;
                offer(it, -1);
                k++;
            end else begin
                len = $urandom_range(1, 6);
                style = $urandom_range(0, 3);
                ch = $urandom_range(0, 1) ? CH_W'($urandom_range(0, 7)) : CH_W'($urandom);
                for (int j = 0; j < len; j++) begin
                    it.func = FUNC_SAMPLE;
                    it.ch = ch;
                    it.fend = (j == len - 1);
                    it.now = clock_ms;
                    case (style)
                        0: it.smp = SMP_W'($urandom);
                        1: it.smp = SMP_W'($urandom_range(0, 600) - 300);
                        2: it.smp = '0;
                        default: it.smp = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                    endcase
                    offer(it, -1);
                    k++;
                end
            end
        end
    endtask

    // result side: check each taken level, idle in random bursts
    initial begin
        level_rpt_t  got;
        level_rpt_t  exp_r;
        int unsigned quiet_left;
        int unsigned ready_left;
        quiet_left = 0;
        ready_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.ch = m_tdata[CH_W-1:0];
                got.lvl = m_tdata[CH_W+LVL_W-1:CH_W];
                got.tick = m_tuser;
                got.last = m_tlast;
                results_seen++;
                if (level_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected level: ch %0d lvl %0d tick %0b last %0b",
                                 got.ch, got.lvl, got.tick, got.last);
                    end
                end else begin
                    exp_r = level_due.pop_front();
                    if (got.ch !== exp_r.ch || got.lvl !== exp_r.lvl ||
                        got.tick !== exp_r.tick || got.last !== exp_r.last) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("mismatch at %0t: want ch %0d lvl %0d tick %0b last %0b",
                                     $realtime, exp_r.ch, exp_r.lvl, exp_r.tick, exp_r.last);
                            $display("                  got  ch %0d lvl %0d tick %0b last %0b",
                                     got.ch, got.lvl, got.tick, got.last);
                        end
                    end
                end
            end
            // long hold-off on request, otherwise short random stalls
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                quiet_left = 400;
                ready_left = 0;
            end
            if (quiet_left > 0) begin
                quiet_left--;
                m_tready <= 1'b0;
            end else if (calm || ready_left > 0) begin
                if (ready_left > 0) begin
                    ready_left--;
                end
                m_tready <= 1'b1;
            end else if ($urandom_range(0, 2) == 0) begin
                quiet_left = $urandom_range(0, 12);
                m_tready <= 1'b0;
            end else begin
                ready_left = $urandom_range(1, 40);
                m_tready <= 1'b1;
            end
        end
    end

    // stimulus
    initial begin
        pcm_item_t it;
        mismatch_count = 0;
        results_seen = 0;
        items_sent = 0;
        ticks_sent = 0;
        frames_sent = 0;
        calm = 1'b0;
        hold_off_req = 1'b0;
        clock_ms = 32'd1000;
        frame_sq_sum = '0;
        frame_len = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            level_mem[i] = '0;
            talk_mem[i] = '0;
        end
        decay_on = RST_DECAY_ENABLE;
        decay_mul = RST_DECAY_FACTOR;
        hold_len = RST_HOLD_MS;

        // directed table, register defaults
        add_row(FUNC_TICK,    0,      0,     1'b0, 32'd0,   0);     // all levels zero
        add_row(FUNC_SAMPLE,  0,      32767, 1'b1, 32'd100, 32767); // positive extreme
        add_row(FUNC_SAMPLE,  63,     -32768, 1'b1, 32'd100, 32768); // full scale
        add_row(FUNC_SAMPLE,  1,      0,     1'b1, 32'd101, 0);
        add_row(FUNC_SAMPLE,  2,      1,     1'b1, 32'd102, 1);
        add_row(FUNC_SAMPLE,  3,      -1,    1'b1, 32'd103, 1);
        add_row(FUNC_SAMPLE,  5,      1000,  1'b0, 32'd104, -1);
        add_row(FUNC_SAMPLE,  5,      -1000, 1'b0, 32'd104, -1);
        add_row(FUNC_TICK,    0,      0,     1'b0, 32'd120, -1);    // open frame, all held
        add_row(FUNC_SAMPLE,  5,      3000,  1'b1, 32'd121, -1);
        add_row(FUNC_SAMPLE,  0,      0,     1'b1, 32'd130, -1);    // release blend
        add_row(FUNC_TICK,    63,     -1,    1'b1, 32'd200, -1);    // decay past hold
        add_row(FUNC_SAMPLE,  4,      'h5555, 1'b1, 32'hFFFF_FFF0, -1);
        add_row(FUNC_SAMPLE,  4,      'hAAAA, 1'b1, 32'hFFFF_FFFF, -1);
        add_row(FUNC_TICK,    0,      0,     1'b0, 32'h0000_0005, -1); // time wraps
        add_row(FUNC_TICK,    0,      0,     1'b0, 32'h8000_0000, -1);
        add_row(FUNC_SAMPLE,  62,     40,    1'b1, 32'h8000_0001, -1);
        add_row(FUNC_TICK,    0,      0,     1'b0, 32'h8000_1000, -1);
        add_row(FUNC_TICK,    0,      0,     1'b0, 32'h8000_2000, -1); // flush to zero
        add_row(FUNC_SAMPLE,  7,      32767, 1'b0, 32'h8000_2001, -1);
        add_row(FUNC_SAMPLE,  7,      -32768, 1'b1, 32'h8000_2001, -1);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[r]) begin
            offer(rows[r].item, rows[r].want);
        end
        settle(16);

        // factor below the clamp, no hold; receiver holds off across a tick
        load_regs(16'h0001, 16'h0000, 16'h0000);
        hold_off_req = 1'b1;
        it = '0;
        it.func = FUNC_TICK;
        it.now = clock_ms;
        offer(it, -1);
        random_traffic(82);
        settle(16);

        // factor above the clamp, longest hold
        load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
        it.func = FUNC_TICK;
        offer(it, -1);
        random_traffic(80);
        settle(16);

        // decay off; sender waits for every level halfway through
        load_regs(16'hFFFE, 16'd20000, 16'd10);
        it.func = FUNC_TICK;
        it.ch = '0;
        it.fend = 1'b0;
        offer(it, -1);
        random_traffic(40);
        settle(16);
        random_traffic(42);
        settle(16);

        // factor at the low clamp edge
        load_regs(16'h0001, 16'd3277, 16'd40);
        it.now = clock_ms;
        offer(it, -1);
        random_traffic(82);
        settle(16);

        // factor at the high clamp edge, no idling from here on
        load_regs(16'h0001, 16'd32440, 16'd5);
        calm = 1'b1;
        offer(it, -1);
        random_traffic(82);
        settle(40);

        if (level_due.size() != 0) begin
            mismatch_count += level_due.size();
            $display("%0d levels never arrived", level_due.size());
        end
        $display("covered %0d items: %0d frame ends, %0d ticks, six register settings",
                 items_sent, frames_sent, ticks_sent);
        $display("%0d levels taken, %0d wrong or unexpected", results_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // run limit
    initial begin
        #25_000_000;
        $display("timeout, items sent %0d, levels due %0d", items_sent, level_due.size());
        $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/rmslvl_pkg.sv
rtl/per_channel_rms_level_tracker_top.sv
bench/tb.sv
